FILE: src/mec_pkg.sv
// mec_pkg: shared constants and the queue item type for the escape counter
// no dependencies
package mec_pkg;

	localparam int FRAC_BITS = 28;
	localparam int C_W       = 32;
	localparam int CNT_W     = 8;
	localparam int ZW        = FRAC_BITS + 2;
	localparam int PW        = 2 * ZW;
	localparam int SW        = ((FRAC_BITS + 4 > C_W) ? FRAC_BITS + 4 : C_W) + 2;
	localparam int QDEPTH    = 2;
	localparam int QAW       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW       = $clog2(QDEPTH + 1);

	localparam logic signed [SW-1:0] TWO_FIX     = SW'(1) <<< (FRAC_BITS + 1);
	localparam logic signed [SW-1:0] NEG_TWO_FIX = -TWO_FIX;
	localparam logic signed [SW-1:0] FOUR_FIX    = SW'(1) <<< (FRAC_BITS + 2);

	localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(255);

	typedef struct packed {
		logic signed [C_W-1:0] c_real;
		logic signed [C_W-1:0] c_imag;
		logic                  far;
	} mec_item_t;

	typedef struct packed {
		logic      valid;
		mec_item_t item;
	} mec_head_t;

endpackage

FILE: src/mec_front.sv
// mec_front: input register and classification of points far from the origin
// depends on mec_pkg
module mec_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [mec_pkg::C_W-1:0] c_real,
	input  logic signed [mec_pkg::C_W-1:0] c_imag,
	input  logic                           q_full,
	output logic                           push,
	output mec_pkg::mec_item_t             push_item
);
	import mec_pkg::*;

	logic            valid_s1;
	mec_item_t       item_s1;
	logic signed [SW-1:0] cr_ext;
	logic signed [SW-1:0] ci_ext;
	logic            far_c;
	logic            accept;

	// first iteration gives z = c, so a c with |re| or |im| of two or more escapes at once
	always_comb begin
		cr_ext = SW'(c_real);
		ci_ext = SW'(c_imag);
		far_c  = (cr_ext >= TWO_FIX) || (cr_ext <= NEG_TWO_FIX) ||
		         (ci_ext >= TWO_FIX) || (ci_ext <= NEG_TWO_FIX);
	end

	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.c_real <= c_real;
			item_s1.c_imag <= c_imag;
			item_s1.far    <= far_c;
		end
	end

endmodule

FILE: src/mec_queue.sv
// mec_queue: short fifo between the front and the iteration engine
// depends on mec_pkg
module mec_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mec_pkg::mec_item_t push_item,
	input  logic               pop,
	output logic               full,
	output mec_pkg::mec_head_t head
);
	import mec_pkg::*;

	mec_item_t        mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == QCW'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	function automatic logic [QAW-1:0] ptr_next(input logic [QAW-1:0] p);
		return (p == QAW'(QDEPTH - 1)) ? '0 : QAW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= QCW'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= QCW'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: src/mec_back.sv
// mec_back: z = z*z + c iteration engine, one iteration per cycle, and result register
// depends on mec_pkg
module mec_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mec_pkg::CNT_W-1:0]  max_iter,
	input  mec_pkg::mec_head_t         head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [mec_pkg::CNT_W-1:0]  escape_count
);
	import mec_pkg::*;

	logic                    busy_q;
	logic signed [ZW-1:0]    x_q;
	logic signed [ZW-1:0]    y_q;
	logic signed [C_W-1:0]   cr_q;
	logic signed [C_W-1:0]   ci_q;
	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	logic [CNT_W-1:0]        out_count_q;

	logic signed [PW-1:0]    xx_p;
	logic signed [PW-1:0]    yy_p;
	logic signed [PW-1:0]    xy_p;
	logic signed [SW-1:0]    sq_x;
	logic signed [SW-1:0]    sq_y;
	logic signed [SW-1:0]    xy2;
	logic signed [SW-1:0]    mod_sum;
	logic signed [SW-1:0]    nx;
	logic signed [SW-1:0]    ny;
	logic                    esc_mod;
	logic                    esc_far;
	logic                    at_limit;
	logic [CNT_W-1:0]        cnt_inc;
	logic                    out_free;
	logic                    done;
	logic [CNT_W-1:0]        done_cnt;
	logic [CNT_W-1:0]        far_cnt;

	function automatic logic [CNT_W-1:0] fold(input logic [CNT_W-1:0] c,
	                                          input logic [CNT_W-1:0] lim);
		return (c == lim) ? '0 : c;
	endfunction

	// products of the current z also give |z|^2 of the previous iteration
	always_comb begin
		xx_p     = x_q * x_q;
		yy_p     = y_q * y_q;
		xy_p     = x_q * y_q;
		sq_x     = SW'(xx_p >>> FRAC_BITS);
		sq_y     = SW'(yy_p >>> FRAC_BITS);
		xy2      = SW'(xy_p >>> (FRAC_BITS - 1));
		mod_sum  = sq_x + sq_y;
		nx       = sq_x - sq_y + SW'(cr_q);
		ny       = xy2 + SW'(ci_q);
		esc_mod  = (mod_sum >= FOUR_FIX);
		esc_far  = (nx >= TWO_FIX) || (nx <= NEG_TWO_FIX) ||
		           (ny >= TWO_FIX) || (ny <= NEG_TWO_FIX);
		at_limit = (count_q == max_iter);
		cnt_inc  = CNT_W'(count_q + 1'b1);
		done     = esc_mod || at_limit || esc_far;
		done_cnt = (esc_mod || at_limit) ? count_q : cnt_inc;
		far_cnt  = (max_iter == '0) ? '0 : CNT_W'(1);
	end

	assign out_free     = !out_valid_q || !out_stall;
	assign pop          = !busy_q && head.valid && (!head.item.far || out_free);
	assign out_valid    = out_valid_q;
	assign escape_count = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_count_q <= '0;
			count_q     <= '0;
			x_q         <= '0;
			y_q         <= '0;
			cr_q        <= '0;
			ci_q        <= '0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (pop) begin
					if (head.item.far) begin
						out_valid_q <= 1'b1;
						out_count_q <= fold(far_cnt, max_iter);
					end else begin
						busy_q  <= 1'b1;
						count_q <= '0;
						x_q     <= '0;
						y_q     <= '0;
						cr_q    <= head.item.c_real;
						ci_q    <= head.item.c_imag;
					end
				end
			end else if (done) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
					out_count_q <= fold(done_cnt, max_iter);
					busy_q      <= 1'b0;
				end
			end else begin
				x_q     <= ZW'(nx);
				y_q     <= ZW'(ny);
				count_q <= cnt_inc;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (count_q <= max_iter))
		else $error("iteration count passed the limit");

	a_z_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (x_q != {1'b1, {(ZW-1){1'b0}}} && y_q != {1'b1, {(ZW-1){1'b0}}}))
		else $error("z held at magnitude two");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_count_q != {CNT_W{1'b1}}))
		else $error("result equals the largest count");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && pop && !head.item.far) |=> (busy_q && count_q == '0))
		else $error("engine did not start from zero");
`endif

endmodule

FILE: src/mandelbrot_escape_count_top.sv
// mandelbrot_escape_count_top: escape-time counter, front, queue and engine
// depends on mec_pkg, mec_front, mec_queue, mec_back
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+-----------------------------
//  in      | in_valid, in_stall, c_real, c_imag        | in_valid && !in_stall
//  out     | out_valid, out_stall, escape_count        | out_valid && !out_stall
//  cfg     | cfg_wr_en, cfg_wr_data (max_iter)         | cfg_wr_en
//
// the engine does one complex-square iteration per cycle, one multiplier set
// points with |re| or |im| of two or more are not iterated by the engine
// arst_n clears all control and sets max_iter to 255
// a stalled output holds a finished result in the engine; the queue keeps taking up to two points
module mandelbrot_escape_count_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [mec_pkg::C_W-1:0] c_real,
	input  logic signed [mec_pkg::C_W-1:0] c_imag,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mec_pkg::CNT_W-1:0]      escape_count,
	input  logic                           cfg_wr_en,
	input  logic [mec_pkg::CNT_W-1:0]      cfg_wr_data
);
	import mec_pkg::*;

	logic [CNT_W-1:0] max_iter_q;
	logic             q_full;
	logic             push;
	mec_item_t        push_item;
	logic             pop;
	mec_head_t        head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RST;
		end else if (cfg_wr_en) begin
			max_iter_q <= cfg_wr_data;
		end
	end

	mec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.c_real    (c_real),
		.c_imag    (c_imag),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	mec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.head      (head)
	);

	mec_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_iter     (max_iter_q),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.escape_count (escape_count)
	);

endmodule
